FILE: design/lfpc_pkg.sv
// shared types and constants of the line framer with port command capture
`default_nettype none

package lfpc_pkg;

  localparam int unsigned LEN_OW = 10;

  localparam logic [7:0] LF_BYTE = 8'h0a;
  localparam logic [7:0] CR_BYTE = 8'h0d;

  localparam logic [1:0] DELIM_NONE = 2'd0;
  localparam logic [1:0] DELIM_LF   = 2'd1;
  localparam logic [1:0] DELIM_CRLF = 2'd2;

  localparam logic [7:0] PORT_WORD [4] = '{8'h70, 8'h6f, 8'h72, 8'h74};

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_READ = 1'b1
  } lfpc_cmd_e;

  typedef enum logic {
    KIND_LINE_END = 1'b0,
    KIND_READ     = 1'b1
  } lfpc_kind_e;

  typedef enum logic {
    CLASS_UNKNOWN = 1'b0,
    CLASS_PORT    = 1'b1
  } lfpc_class_e;

  typedef struct packed {
    lfpc_cmd_e  command;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } lfpc_in_t;

  typedef struct packed {
    lfpc_kind_e         result_kind;
    lfpc_class_e        command_class;
    logic [LEN_OW-1:0]  line_length;
    logic [1:0]         delimiter_length;
    logic               line_truncated;
    logic [LEN_OW-1:0]  port_line_length;
    logic [7:0]         read_byte;
  } lfpc_out_t;

  // result of the framing stage, read byte still to be merged
  typedef struct packed {
    lfpc_kind_e         result_kind;
    lfpc_class_e        command_class;
    logic [LEN_OW-1:0]  line_length;
    logic [1:0]         delimiter_length;
    logic               line_truncated;
    logic [LEN_OW-1:0]  port_line_length;
    logic               rd_ok;
  } lfpc_res_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/lfpc_if.sv
// valid/ready channel interfaces for input and result transactions
`default_nettype none

interface lfpc_in_if import lfpc_pkg::*; ();
  logic     valid;
  logic     ready;
  lfpc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfpc_out_if import lfpc_pkg::*; ();
  logic      valid;
  logic      ready;
  lfpc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lfpc_mem.sv
// two-bank line store, one write port and one registered read port
`default_nettype none

module lfpc_mem #(
  parameter int unsigned AW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW:0]   wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW:0]   rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem_q [2**(AW+1)];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/lfpc_frame.sv
// line framing state, prefix match, store addressing and first result stage
`default_nettype none

module lfpc_frame import lfpc_pkg::*; #(
  parameter int unsigned MAX_LINE = 512
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire lfpc_in_t                         in_data_i,
  output logic                                  in_ready_o,
  input  wire logic                             adv_i,
  output logic                                  wr_en_o,
  output logic [$clog2(MAX_LINE):0]             wr_addr_o,
  output logic [7:0]                            wr_data_o,
  output logic                                  rd_en_o,
  output logic [$clog2(MAX_LINE):0]             rd_addr_o,
  output logic                                  s1_valid_o,
  output lfpc_res_t                             s1_res_o
);

  localparam int unsigned AW   = $clog2(MAX_LINE);
  localparam int unsigned CL_W = $clog2(MAX_LINE + 2);
  localparam logic [CL_W-1:0] MaxLen   = CL_W'(MAX_LINE);
  localparam logic [CL_W-1:0] MaxLenP1 = CL_W'(MAX_LINE + 1);
  localparam logic [CL_W-1:0] PrefixLen = CL_W'(4);

  logic            bank_q, bank_d;
  logic [CL_W-1:0] cur_q, cur_d;
  logic            prefix_q, prefix_d;
  logic            cr_q, cr_d;
  logic            ovf_q, ovf_d;
  logic [CL_W-1:0] stored_q, stored_d;
  lfpc_class_e     last_q, last_d;
  logic            s1_valid_q, s1_valid_d;
  lfpc_res_t       res_q, res_d;

  logic            accept;
  logic            is_lf;
  logic [CL_W-1:0] content;
  logic [CL_W-1:0] len;
  logic            trunc;
  logic            cls;

  assign in_ready_o = !s1_valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_lf      = (in_data_i.data_byte == LF_BYTE);

  assign content = cur_q - CL_W'(cr_q);
  assign len     = (content > MaxLen) ? MaxLen : content;
  assign trunc   = ovf_q || (cur_q == MaxLenP1 && !cr_q);
  assign cls     = (content >= PrefixLen) && prefix_q;

  always_comb begin
    bank_d     = bank_q;
    cur_d      = cur_q;
    prefix_d   = prefix_q;
    cr_d       = cr_q;
    ovf_d      = ovf_q;
    stored_d   = stored_q;
    last_d     = last_q;
    s1_valid_d = s1_valid_q && !adv_i;
    res_d      = res_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = {!bank_q, cur_q[AW-1:0]};
    wr_data_o  = in_data_i.data_byte;
    rd_en_o    = 1'b0;
    rd_addr_o  = {bank_q, AW'(in_data_i.read_index)};

    if (accept) begin
      if (in_data_i.command == CMD_READ) begin
        rd_en_o                = 1'b1;
        s1_valid_d             = 1'b1;
        res_d.result_kind      = KIND_READ;
        res_d.command_class    = last_q;
        res_d.line_length      = '0;
        res_d.delimiter_length = DELIM_NONE;
        res_d.line_truncated   = 1'b0;
        res_d.port_line_length = LEN_OW'(stored_q);
        res_d.rd_ok            = (32'(in_data_i.read_index) < 32'(stored_q));
      end else if (!is_lf) begin
        if (cur_q < PrefixLen &&
            fold_lower(in_data_i.data_byte) != PORT_WORD[cur_q[1:0]]) begin
          prefix_d = 1'b0;
        end
        if (cur_q < MaxLen) begin
          wr_en_o = 1'b1;
        end
        if (cur_q >= MaxLenP1) begin
          ovf_d = 1'b1;
        end else begin
          cur_d = cur_q + CL_W'(1);
        end
        cr_d = (in_data_i.data_byte == CR_BYTE);
      end else begin
        if (cls) begin
          bank_d   = !bank_q;
          stored_d = len;
        end
        last_d                 = cls ? CLASS_PORT : CLASS_UNKNOWN;
        s1_valid_d             = 1'b1;
        res_d.result_kind      = KIND_LINE_END;
        res_d.command_class    = cls ? CLASS_PORT : CLASS_UNKNOWN;
        res_d.line_length      = LEN_OW'(len);
        res_d.delimiter_length = cr_q ? DELIM_CRLF : DELIM_LF;
        res_d.line_truncated   = trunc;
        res_d.port_line_length = cls ? LEN_OW'(len) : LEN_OW'(stored_q);
        res_d.rd_ok            = 1'b0;
        cur_d    = '0;
        prefix_d = 1'b1;
        cr_d     = 1'b0;
        ovf_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= 1'b0;
      cur_q      <= '0;
      prefix_q   <= 1'b1;
      cr_q       <= 1'b0;
      ovf_q      <= 1'b0;
      stored_q   <= '0;
      last_q     <= CLASS_UNKNOWN;
      s1_valid_q <= 1'b0;
    end else begin
      bank_q     <= bank_d;
      cur_q      <= cur_d;
      prefix_q   <= prefix_d;
      cr_q       <= cr_d;
      ovf_q      <= ovf_d;
      stored_q   <= stored_d;
      last_q     <= last_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_res_o   = res_q;

endmodule

`default_nettype wire

FILE: design/lfpc_out.sv
// output register, merges read data into the result transaction
`default_nettype none

module lfpc_out import lfpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s1_valid_i,
  input  wire lfpc_res_t   s1_res_i,
  input  wire logic [7:0]  rd_data_i,
  output logic             adv_o,
  lfpc_out_if.source       out_o
);

  logic      out_valid_q, out_valid_d;
  lfpc_out_t out_data_q, out_data_d;

  assign adv_o = s1_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    if (adv_o) begin
      out_valid_d                 = 1'b1;
      out_data_d.result_kind      = s1_res_i.result_kind;
      out_data_d.command_class    = s1_res_i.command_class;
      out_data_d.line_length      = s1_res_i.line_length;
      out_data_d.delimiter_length = s1_res_i.delimiter_length;
      out_data_d.line_truncated   = s1_res_i.line_truncated;
      out_data_d.port_line_length = s1_res_i.port_line_length;
      out_data_d.read_byte        = s1_res_i.rd_ok ? rd_data_i : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

FILE: design/ftp_line_framer_port_capture_top.sv
// top level of the line framer with port command capture
//
// Takes one transaction per cycle, data bytes and read requests alike, with
// no gaps between them while the output does not stall. A line end report
// or a read result reaches the output through the framing stage and the
// registered read port of the line store, then through the output
// register. Data bytes without LF give no result. The line store holds two
// banks of 2**clog2(MAX_LINE) bytes in a single memory with one write and
// one read port; the current line fills one bank while the latest port line
// stays readable in the other, so reads and writes never meet the same entry.
// The store needs no clearing after reset. Output stalls hold the result and
// stop intake only once both result stages are full.
`default_nettype none

module ftp_line_framer_port_capture_top import lfpc_pkg::*; #(
  parameter int unsigned MAX_LINE = 512
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lfpc_in_if.sink    in_i,
  lfpc_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_LINE);

  logic          adv;
  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW:0]   rd_addr;
  logic [7:0]    rd_data;
  logic          s1_valid;
  lfpc_res_t     s1_res;

  lfpc_frame #(
    .MAX_LINE (MAX_LINE)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .adv_i      (adv),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_valid_o (s1_valid),
    .s1_res_o   (s1_res)
  );

  lfpc_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lfpc_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_res_i   (s1_res),
    .rd_data_i  (rd_data),
    .adv_o      (adv),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: design/lfpc_chk.sv
// port-level checks on result transactions, bound to the top level
`default_nettype none

module lfpc_chk import lfpc_pkg::*; #(
  parameter int unsigned MAX_LINE = 512
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire lfpc_out_t out_data_i
);

  localparam int unsigned CutLen = MAX_LINE % (2 ** LEN_OW);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_kind == KIND_LINE_END |->
      (out_data_i.delimiter_length == DELIM_LF ||
       out_data_i.delimiter_length == DELIM_CRLF) &&
      out_data_i.read_byte == 8'h00 &&
      (!out_data_i.line_truncated || 32'(out_data_i.line_length) == CutLen))
    else $error("malformed line end report");

  a_port_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_kind == KIND_LINE_END &&
    out_data_i.command_class == CLASS_PORT |->
      out_data_i.port_line_length == out_data_i.line_length)
    else $error("port line length not taken from port line");

  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_kind == KIND_READ |->
      out_data_i.line_length == '0 &&
      out_data_i.delimiter_length == DELIM_NONE &&
      !out_data_i.line_truncated)
    else $error("read result carries line end fields");

endmodule

bind ftp_line_framer_port_capture_top lfpc_chk #(
  .MAX_LINE (MAX_LINE)
) u_lfpc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

FILE: tb/sv/lfpc_line_checker.sv
// checker that predicts line end reports and port line reads and compares them
`default_nettype none

module lfpc_line_checker import lfpc_pkg::*; #(
  parameter int unsigned MAX_LINE = 512
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfpc_in_if        in_mon,
  lfpc_out_if       out_mon,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  // two banks: the latest port line in one, the line being framed in the other
  logic [7:0]  line_mem [2*MAX_LINE];
  logic        port_bank;
  int unsigned cur_len;
  logic        prefix_ok;
  logic        cr_seen;
  logic        overflow;
  int unsigned port_len;
  lfpc_class_e last_cls;

  lfpc_out_t   line_reports [$];
  int          fails;
  int          checked;

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic frame_transaction(input lfpc_in_t t);
    lfpc_out_t   r;
    logic [7:0]  folded;
    int unsigned pos;
    int unsigned content;
    int unsigned fill_base;
    r = '0;
    if (t.command == CMD_READ) begin
      r.result_kind      = KIND_READ;
      r.command_class    = last_cls;
      r.line_length      = '0;
      r.delimiter_length = DELIM_NONE;
      r.line_truncated   = 1'b0;
      r.port_line_length = port_len[LEN_OW-1:0];
      if (t.read_index < port_len) begin
        r.read_byte = line_mem[(port_bank ? MAX_LINE : 0) + t.read_index];
      end
      line_reports.push_back(r);
    end else if (t.data_byte != LF_BYTE) begin
      pos       = cur_len;
      fill_base = port_bank ? 0 : MAX_LINE;
      folded    = (t.data_byte >= 8'h41 && t.data_byte <= 8'h5a) ?
                  t.data_byte + 8'h20 : t.data_byte;
      if (pos < 4 && folded != PORT_WORD[pos]) begin
        prefix_ok = 1'b0;
      end
      if (pos < MAX_LINE) begin
        line_mem[fill_base + pos] = t.data_byte;
      end
      if (pos >= MAX_LINE + 1) begin
        overflow = 1'b1;
      end else begin
        cur_len = pos + 1;
      end
      cr_seen = (t.data_byte == CR_BYTE);
    end else begin
      content = cur_len - (cr_seen ? 1 : 0);
      r.result_kind      = KIND_LINE_END;
      r.line_truncated   = overflow || (cur_len == MAX_LINE + 1 && !cr_seen);
      r.line_length      = (content > MAX_LINE) ? MAX_LINE : content;
      r.delimiter_length = cr_seen ? DELIM_CRLF : DELIM_LF;
      r.command_class    = (content >= 4 && prefix_ok) ? CLASS_PORT : CLASS_UNKNOWN;
      if (r.command_class == CLASS_PORT) begin
        port_bank = ~port_bank;
        port_len  = r.line_length;
      end
      last_cls           = r.command_class;
      r.port_line_length = port_len[LEN_OW-1:0];
      r.read_byte        = '0;
      line_reports.push_back(r);
      cur_len   = 0;
      prefix_ok = 1'b1;
      cr_seen   = 1'b0;
      overflow  = 1'b0;
    end
  endtask

  task automatic compare_report(input lfpc_out_t got);
    lfpc_out_t want;
    if (line_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
      fails++;
    end else begin
      want = line_reports.pop_front();
      checked++;
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("command_class", want.command_class, got.command_class);
      check_field("line_length", want.line_length, got.line_length);
      check_field("delimiter_length", want.delimiter_length, got.delimiter_length);
      check_field("line_truncated", want.line_truncated, got.line_truncated);
      check_field("port_line_length", want.port_line_length, got.port_line_length);
      check_field("read_byte", want.read_byte, got.read_byte);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_bank = 1'b0;
      cur_len   = 0;
      prefix_ok = 1'b1;
      cr_seen   = 1'b0;
      overflow  = 1'b0;
      port_len  = 0;
      last_cls  = CLASS_UNKNOWN;
      line_reports.delete();
      fails     = 0;
      checked   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // results leave through registered stages after their transaction, so compare first
      if (out_mon.valid && out_mon.ready) begin
        compare_report(out_mon.data);
      end
      if (in_mon.valid && in_mon.ready) begin
        frame_transaction(in_mon.data);
      end
      fail_count_o <= fails;
      pending_o    <= line_reports.size();
      checked_o    <= checked;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/ftp_line_framer_port_capture_top_test.sv
// testbench top: stimulus, idling phases, watchdog and verdict for the line framer
`default_nettype none

module ftp_line_framer_port_capture_top_test;
  import lfpc_pkg::*;

  localparam int unsigned LINE_BYTES  = 512;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 20;

  logic clk_i;
  logic rst_ni;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;
  int   checked;
  int   items_sent   = 0;
  int   lines_sent   = 0;
  int   reads_sent   = 0;

  lfpc_in_if  in_ch ();
  lfpc_out_if out_ch ();

  ftp_line_framer_port_capture_top #(.MAX_LINE(LINE_BYTES)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  lfpc_line_checker #(.MAX_LINE(LINE_BYTES)) u_line_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input lfpc_in_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    lfpc_in_t t;
    t.command    = CMD_DATA;
    t.data_byte  = b;
    t.read_index = 9'($urandom_range(0, 511));
    send_item(t);
  endtask

  task automatic send_read(input int idx);
    lfpc_in_t t;
    t.command    = CMD_READ;
    t.data_byte  = 8'($urandom_range(0, 255));
    t.read_index = 9'(idx);
    send_item(t);
    reads_sent++;
  endtask

  task automatic send_line(input logic [7:0] body [$], input bit with_cr, input int read_pct);
    foreach (body[i]) begin
      if ($urandom_range(0, 99) < read_pct) begin
        send_read($urandom_range(0, 15));
      end
      send_byte(body[i]);
    end
    if (with_cr) begin
      send_byte(CR_BYTE);
    end
    send_byte(LF_BYTE);
    lines_sent++;
  endtask

  // letter of the command word in random case, optionally one letter off
  function automatic logic [7:0] port_letter(input int pos, input bit miss);
    logic [7:0] c;
    c = PORT_WORD[pos];
    if (miss) begin
      c = c ^ 8'h01;
    end
    if ($urandom_range(0, 1) != 0) begin
      c = c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 8) begin
      return CR_BYTE;
    end
    do b = 8'($urandom_range(0, 255)); while (b == LF_BYTE);
    return b;
  endfunction

  task automatic send_random_line();
    logic [7:0] body [$];
    int         kind;
    int         prefix_len;
    int         miss_at;
    kind       = $urandom_range(0, 99);
    prefix_len = 0;
    miss_at    = -1;
    if (kind < 40) begin
      prefix_len = 4;
    end else if (kind < 50) begin
      prefix_len = $urandom_range(1, 3);
    end else if (kind < 60) begin
      prefix_len = 4;
      miss_at    = $urandom_range(0, 3);
    end
    for (int i = 0; i < prefix_len; i++) begin
      body.push_back(port_letter(i, i == miss_at));
    end
    repeat ($urandom_range(0, 10)) body.push_back(body_byte());
    send_line(body, $urandom_range(0, 1) != 0, 8);
  endtask

  // lines around the store size, then reads deep into the stored line
  task automatic send_long_line(input int n, input bit port, input bit with_cr);
    logic [7:0] body [$];
    if (port) begin
      for (int i = 0; i < 4; i++) begin
        body.push_back(port_letter(i, 1'b0));
      end
    end else begin
      body.push_back(8'h78);
    end
    while (body.size() < n) body.push_back(body_byte());
    send_line(body, with_cr, 1);
    send_read(LINE_BYTES - 1);
    send_read(LINE_BYTES - 2);
    repeat (6) send_read($urandom_range(256, 511));
  endtask

  task automatic send_directed();
    logic [7:0] body [$];
    send_read(0);
    send_line(body, 1'b0, 0);
    send_line(body, 1'b1, 0);
    body = '{8'h50, 8'h6f, 8'h52, 8'h74};
    send_line(body, 1'b1, 0);
    send_read(3);
    send_read(4);
    send_read(511);
    body = '{8'h70, 8'h6f, 8'h72};
    send_line(body, 1'b0, 0);
    body = '{8'h70, 8'h6f, 8'h72, 8'h74, 8'h00, 8'hff};
    send_line(body, 1'b0, 0);
    send_read(5);
  endtask

  initial begin
    int start;
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          send_directed();
        end
        1: begin
          idle_pct  = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct  = 38;
          stall_pct = 38;
          send_long_line(LINE_BYTES + 1, 1'b1, 1'b0);
        end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 20) begin
          send_read(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 511));
        end else begin
          send_random_line();
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d transactions over four idling phases: %0d lines, %0d port line reads",
             items_sent, lines_sent, reads_sent);
    $display("%0d results checked, one line past the %0d-byte store included",
             checked, LINE_BYTES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
